@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off in reset.
`define CHK_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off in reset.
`define CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/lsd_pkg.sv @@
package lsd_pkg;

    localparam int DEPTH     = 1024;
    localparam int ADDR_W    = 32;
    localparam int LIM_W     = 11;
    localparam int DIST_W    = 10;
    localparam int CNT_W     = $clog2(DEPTH + 1);

    localparam int GRP_SZ    = 32;
    localparam int GRP_IDX_W = $clog2(GRP_SZ);
    localparam int NUM_GRP   = (DEPTH + GRP_SZ - 1) / GRP_SZ;
    localparam int NUM_CELL  = NUM_GRP * GRP_SZ;
    localparam int GRP_SEL_W = (NUM_GRP > 1) ? $clog2(NUM_GRP) : 1;
    localparam int POS_W     = GRP_SEL_W + GRP_IDX_W;
    localparam int POSX_W    = (POS_W > DIST_W) ? POS_W : DIST_W;

    localparam logic [LIM_W-1:0] LIM_RESET = 11'd1024;

    typedef struct packed {
        logic cmp_en;
        logic grp_en;
        logic upd_en;
    } t_cell_ctl;

endpackage

@@ rtl/lsd_cell.sv @@
module lsd_cell (
    input  logic                      i_clk,
    input  lsd_pkg::t_cell_ctl        i_ctl,
    input  logic [lsd_pkg::ADDR_W-1:0] i_addr,
    input  logic [lsd_pkg::ADDR_W-1:0] i_prev_entry,
    input  logic                      i_occupied,
    input  logic                      i_shift,
    output logic [lsd_pkg::ADDR_W-1:0] o_entry,
    output logic                      o_match
);

    logic [lsd_pkg::ADDR_W-1:0] r_entry;
    logic                       r_match;

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp_en) begin
            r_match <= i_occupied && (r_entry == i_addr);
        end
        if (i_ctl.upd_en && i_shift) begin
            r_entry <= i_prev_entry;
        end
    end

    assign o_entry = r_entry;
    assign o_match = r_match;

endmodule

@@ rtl/lsd_group.sv @@
module lsd_group (
    input  logic                            i_clk,
    input  lsd_pkg::t_cell_ctl              i_ctl,
    input  logic [lsd_pkg::GRP_SZ-1:0]      i_match,
    output logic                            o_any,
    output logic [lsd_pkg::GRP_SZ-1:0]      o_excl,
    output logic [lsd_pkg::GRP_IDX_W-1:0]   o_first
);

    logic [lsd_pkg::GRP_SZ-1:0]    n_excl;
    logic [lsd_pkg::GRP_SZ-1:0]    w_first_oh;
    logic [lsd_pkg::GRP_IDX_W-1:0] n_first;
    logic [lsd_pkg::GRP_SZ-1:0]    r_excl;
    logic [lsd_pkg::GRP_IDX_W-1:0] r_first;
    logic                          r_any;

    always_comb begin
        n_first = '0;
        for (int k = 0; k < lsd_pkg::GRP_SZ; k++) begin
            n_excl[k] = |(i_match & ~({lsd_pkg::GRP_SZ{1'b1}} << k));
        end
        w_first_oh = i_match & ~n_excl;
        for (int k = 0; k < lsd_pkg::GRP_SZ; k++) begin
            if (w_first_oh[k]) begin
                n_first = n_first | lsd_pkg::GRP_IDX_W'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.grp_en) begin
            r_any   <= |i_match;
            r_excl  <= n_excl;
            r_first <= n_first;
        end
    end

    assign o_any   = r_any;
    assign o_excl  = r_excl;
    assign o_first = r_first;

endmodule

@@ rtl/lru_stack_distance_core.sv @@
// Bounded LRU stack-distance engine. Each input beat carries one address; the
// output beat reports a hit flag and the 0-based depth of that address in the
// stack of recent addresses (zero on a miss), after which the address moves to
// the top. A row of cells holds the stack and compares all entries at once.
// Each item passes in turn through the accept, the parallel compare in every
// cell, a priority encode inside each group of 32 cells, the prefix across
// groups, and the shift of the cell row, which also loads the output register.
// The next address is taken while a finished result still waits on the output
// port; the shift step waits only if the previous result has not been taken.
// A stack_limit of zero acts as one, a value above the depth acts as the
// depth, and lowering the limit drops the least recent entries at once.
module lru_stack_distance_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [lsd_pkg::ADDR_W-1:0]  i_address,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_hit,
    output logic [lsd_pkg::DIST_W-1:0]  o_distance,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [lsd_pkg::LIM_W-1:0]   i_cfg_stack_limit
);

    localparam int EL_W  = (lsd_pkg::LIM_W > lsd_pkg::CNT_W) ? lsd_pkg::LIM_W : lsd_pkg::CNT_W;
    localparam int CIX_W = $clog2(lsd_pkg::NUM_CELL) + 1;
    localparam int OC_W  = (CIX_W > lsd_pkg::CNT_W) ? CIX_W : lsd_pkg::CNT_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CMP  = 3'd1;
    localparam logic [2:0] S_GRP  = 3'd2;
    localparam logic [2:0] S_PFX  = 3'd3;
    localparam logic [2:0] S_UPD  = 3'd4;

    function automatic logic [EL_W-1:0] eff_limit(input logic [lsd_pkg::LIM_W-1:0] lim);
        logic [EL_W-1:0] x;
        x = EL_W'(lim);
        if (lim == '0) begin
            return EL_W'(1);
        end else if (x > EL_W'(lsd_pkg::DEPTH)) begin
            return EL_W'(lsd_pkg::DEPTH);
        end
        return x;
    endfunction

    logic [2:0]                    r_state, n_state;
    logic [lsd_pkg::ADDR_W-1:0]    r_addr;
    logic [lsd_pkg::LIM_W-1:0]     r_lim;
    logic [lsd_pkg::CNT_W-1:0]     r_occ, n_occ;
    logic                          r_out_valid;
    logic                          r_hit;
    logic [lsd_pkg::DIST_W-1:0]    r_dist;
    logic [lsd_pkg::NUM_GRP-1:0]   r_grp_excl;
    logic                          r_res_hit;
    logic [lsd_pkg::POSX_W-1:0]    r_res_pos;

    logic [lsd_pkg::NUM_GRP-1:0]   n_grp_excl;
    logic [lsd_pkg::NUM_GRP-1:0]   w_grp_oh;
    logic [lsd_pkg::POSX_W-1:0]    n_res_pos;
    logic [EL_W-1:0]               w_eff;
    logic [EL_W-1:0]               w_cfg_eff;
    logic [EL_W-1:0]               w_occ_x;
    logic                          w_in_acc;
    logic                          w_can_load;
    lsd_pkg::t_cell_ctl            w_ctl;

    logic [lsd_pkg::ADDR_W-1:0]    w_entry [lsd_pkg::NUM_CELL];
    logic [lsd_pkg::NUM_CELL-1:0]  w_match;
    logic [lsd_pkg::NUM_CELL-1:0]  w_excl;
    logic [lsd_pkg::NUM_GRP-1:0]   w_grp_any;
    logic [lsd_pkg::GRP_IDX_W-1:0] w_grp_first [lsd_pkg::NUM_GRP];

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_can_load  = !r_out_valid || i_out_ready;

    assign w_eff     = eff_limit(r_lim);
    assign w_cfg_eff = eff_limit(i_cfg_stack_limit);
    assign w_occ_x   = EL_W'(r_occ);

    always_comb begin
        w_ctl.cmp_en = (r_state == S_CMP);
        w_ctl.grp_en = (r_state == S_GRP);
        w_ctl.upd_en = (r_state == S_UPD) && w_can_load;
    end

    genvar c, g;
    generate
        for (c = 0; c < lsd_pkg::NUM_CELL; c++) begin : g_cell
            logic [lsd_pkg::ADDR_W-1:0] w_prev;
            logic                       w_occupied;
            logic                       w_shift;
            if (c == 0) begin : g_top
                assign w_prev = r_addr;
            end else begin : g_rest
                assign w_prev = w_entry[c-1];
            end
            assign w_occupied = OC_W'(c) < OC_W'(r_occ);
            assign w_shift    = !(r_grp_excl[c / lsd_pkg::GRP_SZ] || w_excl[c]);
            lsd_cell u_cell (
                .i_clk        (i_clk),
                .i_ctl        (w_ctl),
                .i_addr       (r_addr),
                .i_prev_entry (w_prev),
                .i_occupied   (w_occupied),
                .i_shift      (w_shift),
                .o_entry      (w_entry[c]),
                .o_match      (w_match[c])
            );
        end
        for (g = 0; g < lsd_pkg::NUM_GRP; g++) begin : g_grp
            lsd_group u_group (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl),
                .i_match (w_match[g*lsd_pkg::GRP_SZ +: lsd_pkg::GRP_SZ]),
                .o_any   (w_grp_any[g]),
                .o_excl  (w_excl[g*lsd_pkg::GRP_SZ +: lsd_pkg::GRP_SZ]),
                .o_first (w_grp_first[g])
            );
        end
    endgenerate

    always_comb begin
        n_res_pos = '0;
        for (int k = 0; k < lsd_pkg::NUM_GRP; k++) begin
            n_grp_excl[k] = |(w_grp_any & ~({lsd_pkg::NUM_GRP{1'b1}} << k));
        end
        w_grp_oh = w_grp_any & ~n_grp_excl;
        for (int k = 0; k < lsd_pkg::NUM_GRP; k++) begin
            if (w_grp_oh[k]) begin
                n_res_pos = n_res_pos |
                    lsd_pkg::POSX_W'({lsd_pkg::GRP_SEL_W'(k), w_grp_first[k]});
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_occ   = r_occ;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: n_state = S_GRP;
            S_GRP: n_state = S_PFX;
            S_PFX: n_state = S_UPD;
            S_UPD: begin
                if (w_can_load) begin
                    n_state = S_IDLE;
                    if (!r_res_hit) begin
                        n_occ = (w_occ_x < w_eff) ? r_occ + lsd_pkg::CNT_W'(1)
                                                  : lsd_pkg::CNT_W'(w_eff);
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (i_cfg_valid && (w_occ_x > w_cfg_eff)) begin
            n_occ = lsd_pkg::CNT_W'(w_cfg_eff);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_occ       <= '0;
            r_lim       <= lsd_pkg::LIM_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
            if (i_cfg_valid) begin
                r_lim <= i_cfg_stack_limit;
            end
            if (w_ctl.upd_en) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_addr <= i_address;
        end
        if (r_state == S_PFX) begin
            r_grp_excl <= n_grp_excl;
            r_res_hit  <= |w_grp_any;
            r_res_pos  <= n_res_pos;
        end
        if (w_ctl.upd_en) begin
            r_hit  <= r_res_hit;
            r_dist <= r_res_pos[lsd_pkg::DIST_W-1:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_hit       = r_hit;
    assign o_distance  = r_dist;

endmodule

@@ rtl/lsd_chk.sv @@
`include "assert_macros.svh"

module lsd_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_ready,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic                        o_hit,
    input logic [lsd_pkg::DIST_W-1:0]  o_distance
);

    `CHK_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid, "output beat dropped")
    `CHK_NEXT(a_out_stable, o_out_valid && !i_out_ready,
              $stable(o_hit) && $stable(o_distance), "output payload changed while stalled")
    `CHK_SAME(a_miss_zero, o_out_valid && !o_hit, o_distance == '0, "miss with nonzero distance")
    `CHK_SAME(a_busy, i_in_valid && o_in_ready,
              ##1 !o_in_ready ##1 !o_in_ready ##1 !o_in_ready, "input taken during search")

endmodule

bind lru_stack_distance_core lsd_chk u_lsd_chk (.*);

@@ sim/lru_stack_distance_check.sv @@
`timescale 1ns / 1ps
module lru_stack_distance_check (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic [lsd_pkg::ADDR_W-1:0]  i_address,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic                        i_hit,
    input  logic [lsd_pkg::DIST_W-1:0]  i_distance,
    input  logic                        i_cfg_valid,
    input  logic                        i_cfg_ready,
    input  logic [lsd_pkg::LIM_W-1:0]   i_cfg_stack_limit,
    output int                          o_fail_count,
    output int                          o_pending,
    output int                          o_result_count,
    output int                          o_hit_count,
    output int                          o_max_distance
);

    typedef struct packed {
        logic                       hit;
        logic [lsd_pkg::DIST_W-1:0] distance;
    } t_lookup_outcome;

    t_lookup_outcome            pending_outcomes [$];
    logic [lsd_pkg::ADDR_W-1:0] lru_stack [lsd_pkg::DEPTH];
    int unsigned                stack_fill;
    logic [lsd_pkg::LIM_W-1:0]  stack_limit;

    function automatic int unsigned usable_depth(input logic [lsd_pkg::LIM_W-1:0] limit);
        if (limit == '0) begin
            return 1;
        end
        if (limit > lsd_pkg::DEPTH) begin
            return lsd_pkg::DEPTH;
        end
        return limit;
    endfunction

    function automatic t_lookup_outcome lru_lookup(input logic [lsd_pkg::ADDR_W-1:0] addr);
        t_lookup_outcome res;
        int unsigned     cap;
        int unsigned     occ;
        int unsigned     pos;
        int unsigned     keep;
        bit              found;
        cap   = usable_depth(stack_limit);
        occ   = (stack_fill > cap) ? cap : stack_fill;
        found = 1'b0;
        pos   = 0;
        res   = '0;
        for (int unsigned k = 0; k < occ && !found; k++) begin
            if (lru_stack[k] == addr) begin
                found = 1'b1;
                pos   = k;
            end
        end
        if (found) begin
            for (int k = pos; k > 0; k--) begin
                lru_stack[k] = lru_stack[k-1];
            end
            res.hit      = 1'b1;
            res.distance = pos[lsd_pkg::DIST_W-1:0];
        end else begin
            keep = (occ < cap) ? occ : cap - 1;
            for (int k = keep; k > 0; k--) begin
                lru_stack[k] = lru_stack[k-1];
            end
            occ = keep + 1;
        end
        lru_stack[0] = addr;
        stack_fill   = occ;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_lookup_outcome want;
        if (!i_rst_n) begin
            pending_outcomes.delete();
            stack_fill     = 0;
            stack_limit    = lsd_pkg::LIM_RESET;
            o_fail_count   = 0;
            o_result_count = 0;
            o_hit_count    = 0;
            o_max_distance = 0;
            o_pending     <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (pending_outcomes.size() == 0) begin
                    $error("unexpected result beat: hit %0b, distance %0d", i_hit, i_distance);
                    o_fail_count++;
                end else begin
                    want = pending_outcomes.pop_front();
                    o_result_count++;
                    if (i_hit !== want.hit) begin
                        $error("hit: expected %0b, actual %0b", want.hit, i_hit);
                        o_fail_count++;
                    end
                    if (i_distance !== want.distance) begin
                        $error("distance: expected %0d, actual %0d", want.distance, i_distance);
                        o_fail_count++;
                    end
                    if (want.hit) begin
                        o_hit_count++;
                        if (want.distance > o_max_distance) begin
                            o_max_distance = want.distance;
                        end
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                stack_limit = i_cfg_stack_limit;
                if (stack_fill > usable_depth(stack_limit)) begin
                    stack_fill = usable_depth(stack_limit);
                end
            end
            if (i_in_valid && i_in_ready) begin
                pending_outcomes.insert(pending_outcomes.size(), lru_lookup(i_address));
            end
            o_pending <= pending_outcomes.size();
        end
    end

endmodule

@@ sim/lru_stack_distance_core_tb.sv @@
`timescale 1ns / 1ps
module lru_stack_distance_core_tb;

    localparam int CLK_HALF     = 5;
    localparam int RST_CYCLES   = 12;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int TAIL_CYCLES  = 20;
    localparam int PHASE_ITEMS  = 8;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    logic                       i_clk             = 1'b0;
    logic                       i_rst_n           = 1'b0;
    logic                       i_in_valid        = 1'b0;
    logic [lsd_pkg::ADDR_W-1:0] i_address         = '0;
    logic                       i_out_ready       = 1'b0;
    logic                       i_cfg_valid       = 1'b0;
    logic [lsd_pkg::LIM_W-1:0]  i_cfg_stack_limit = '0;
    logic                       o_in_ready;
    logic                       o_out_valid;
    logic                       o_hit;
    logic [lsd_pkg::DIST_W-1:0] o_distance;
    logic                       o_cfg_ready;

    int fail_count;
    int pending;
    int result_count;
    int hit_count;
    int max_distance;
    int cycle_count    = 0;
    int limit_writes   = 0;
    int send_gap_pct   = 0;
    int recv_stall_pct = 0;
    logic [lsd_pkg::ADDR_W-1:0] addr_pool [$];

    lru_stack_distance_core uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_address         (i_address),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_hit             (o_hit),
        .o_distance        (o_distance),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_stack_limit (i_cfg_stack_limit)
    );

    lru_stack_distance_check scoreboard (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .i_in_ready        (o_in_ready),
        .i_address         (i_address),
        .i_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .i_hit             (o_hit),
        .i_distance        (o_distance),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_cfg_stack_limit (i_cfg_stack_limit),
        .o_fail_count      (fail_count),
        .o_pending         (pending),
        .o_result_count    (result_count),
        .o_hit_count       (hit_count),
        .o_max_distance    (max_distance)
    );

    always #CLK_HALF i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("lru_stack_distance_core: mismatch");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic set_idle(input t_idle_mode mode);
        send_gap_pct    = (mode == IDLE_SEND) ? 45 : (mode == IDLE_BOTH) ? 30 : 0;
        recv_stall_pct <= (mode == IDLE_RECV) ? 45 : (mode == IDLE_BOTH) ? 30 : 0;
    endtask

    task automatic send_address(input logic [lsd_pkg::ADDR_W-1:0] addr);
        if ($urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_gap_pct);
        end
        i_in_valid <= 1'b1;
        i_address  <= addr;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic drain_results;
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [lsd_pkg::LIM_W-1:0] value);
        drain_results();
        i_cfg_valid       <= 1'b1;
        i_cfg_stack_limit <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        limit_writes++;
    endtask

    task automatic run_phase(input logic [lsd_pkg::LIM_W-1:0] limit, input int pool_size,
                             input t_idle_mode mode, input bit mid_drain);
        logic [lsd_pkg::ADDR_W-1:0] addr;
        int                         pick;
        write_limit(limit);
        set_idle(mode);
        addr_pool.delete();
        repeat (pool_size) addr_pool.insert(addr_pool.size(), $urandom);
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(99);
            if (pick < 85) begin
                addr = addr_pool[$urandom_range(pool_size - 1)];
            end else if (pick < 95) begin
                addr = $urandom;
            end else begin
                case ($urandom_range(3))
                    0:       addr = '0;
                    1:       addr = '1;
                    2:       addr = 32'd1 << $urandom_range(31);
                    default: addr = ~(32'd1 << $urandom_range(31));
                endcase
            end
            send_address(addr);
            if (mid_drain && n == PHASE_ITEMS / 2) begin
                drain_results();
            end
        end
    endtask

    task automatic deep_sweep;
        logic [lsd_pkg::ADDR_W-1:0] base;
        base = $urandom;
        write_limit(11'd2047);
        set_idle(IDLE_BOTH);
        for (int n = 0; n < lsd_pkg::DEPTH; n++) begin
            send_address(base ^ n);
        end
        send_address(base);
        send_address(base ^ 1);
        send_address(~base);
        send_address(base ^ 2);
        repeat (20) send_address(base ^ $urandom_range(lsd_pkg::DEPTH - 1));
    endtask

    initial begin
        int rand_limit;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_idle(IDLE_NONE);

        send_address(32'h0000_0000);
        send_address(32'hFFFF_FFFF);
        send_address(32'h0000_0000);
        send_address(32'h0000_0000);
        send_address(32'hFFFF_FFFF);
        send_address(32'h8000_0000);
        send_address(32'h0000_0001);
        send_address(32'h7FFF_FFFF);
        send_address(32'hFFFF_FFFE);
        send_address(32'h0000_0000);
        send_address(32'h5555_5555);
        send_address(32'hAAAA_AAAA);
        send_address(32'h5555_5555);

        // A zero limit behaves as a single entry and truncates the stack at once.
        write_limit(11'd0);
        send_address(32'h5555_5555);
        send_address(32'h1234_5678);
        send_address(32'h5555_5555);

        write_limit(11'd2);
        send_address(32'h0000_0001);
        send_address(32'h0000_0002);
        send_address(32'h0000_0001);
        send_address(32'h0000_0003);
        send_address(32'h0000_0002);

        deep_sweep();

        run_phase(11'd17,   22,   IDLE_SEND, 1'b1);
        run_phase(11'd1024, 40,   IDLE_NONE, 1'b0);
        run_phase(11'd1,    3,    IDLE_RECV, 1'b0);
        run_phase(11'd2,    4,    IDLE_BOTH, 1'b1);
        run_phase(11'd3,    5,    IDLE_NONE, 1'b0);
        run_phase(11'd8,    12,   IDLE_SEND, 1'b0);
        run_phase(11'd64,   70,   IDLE_RECV, 1'b1);
        run_phase(11'd1025, 30,   IDLE_BOTH, 1'b0);
        run_phase(11'd1023, 50,   IDLE_NONE, 1'b0);
        rand_limit = $urandom_range(4, 40);
        run_phase(rand_limit[lsd_pkg::LIM_W-1:0], rand_limit + 4, IDLE_BOTH, 1'b0);
        run_phase(11'd0,    3,    IDLE_RECV, 1'b0);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Checked %0d lookups, %0d of them hits, deepest hit at distance %0d.",
                 result_count, hit_count, max_distance);
        $display("Stack limit was rewritten %0d times, from zero up to the 11-bit maximum.",
                 limit_writes);
        if (fail_count == 0) begin
            $display("lru_stack_distance_core: match");
        end else begin
            $display("lru_stack_distance_core: mismatch");
        end
        $finish;
    end

endmodule
